// ===== hdl/cfb_pkg.sv =====
// Package with the item types, framing constants, sequencer states and CRC-16 byte update.
`timescale 1ns / 1ps

package cfb_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  START_BYTE = 8'h55;
  localparam logic [7:0]  END_BYTE   = 8'hAA;

  // One input item.
  typedef struct packed {
    logic [7:0] command_code;
    logic [7:0] highest_index;
    logic [7:0] payload_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // An accepted item with its place in the frame already decided.
  typedef struct packed {
    logic [7:0] command_code;
    logic [7:0] highest_index;
    logic [7:0] payload_byte;
    logic       first;
    logic       last;
  } hold_t;

  // Which byte of the frame the sequencer sends next.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_CMD,
    PH_HI,
    PH_PAY,
    PH_CRCL,
    PH_CRCH,
    PH_END
  } phase_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/cfb_intake.sv =====
// Input register with the frame tracking that marks each item as first and last of a message.
`timescale 1ns / 1ps

module cfb_intake (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfb_pkg::in_item_t in_item,
  input  logic              item_done,
  output logic              hold_valid,
  output cfb_pkg::hold_t    hold
);

  logic           valid_r, valid_nxt;
  cfb_pkg::hold_t hold_r, hold_nxt;
  logic           in_frame_r, in_frame_nxt;
  logic [7:0]     bytes_left_r, bytes_left_nxt;
  logic           accept;
  logic           first, last;

  // A new item enters when the register is empty or its last byte leaves now.
  assign in_ready = !valid_r || item_done;
  assign accept   = in_valid && in_ready;

  // Place of the incoming item in its message.
  always_comb begin
    first = !in_frame_r;
    last  = first ? (in_item.highest_index == 8'd0) : (bytes_left_r <= 8'd1);
  end

  // Next values of the item register and the frame state.
  always_comb begin
    valid_nxt      = valid_r;
    hold_nxt       = hold_r;
    in_frame_nxt   = in_frame_r;
    bytes_left_nxt = bytes_left_r;
    if (item_done) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt              = 1'b1;
      hold_nxt.command_code  = in_item.command_code;
      hold_nxt.highest_index = in_item.highest_index;
      hold_nxt.payload_byte  = in_item.payload_byte;
      hold_nxt.first         = first;
      hold_nxt.last          = last;
      if (last) begin
        in_frame_nxt   = 1'b0;
        bytes_left_nxt = 8'd0;
      end else if (first) begin
        in_frame_nxt   = 1'b1;
        bytes_left_nxt = in_item.highest_index;
      end else begin
        bytes_left_nxt = bytes_left_r - 8'd1;
      end
    end
  end

  // Control state resets; the item payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      in_frame_r   <= 1'b0;
      bytes_left_r <= 8'd0;
    end else begin
      valid_r      <= valid_nxt;
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  assign hold_valid = valid_r;
  assign hold       = hold_r;

endmodule

// ===== hdl/cfb_seq.sv =====
// Byte sequencer with the running CRC and the output register.
`timescale 1ns / 1ps

module cfb_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hold_valid,
  input  cfb_pkg::hold_t     hold,
  output logic               item_done,
  output logic               out_valid,
  input  logic               out_ready,
  output cfb_pkg::out_item_t out_item
);

  cfb_pkg::phase_t    phase_r, phase_nxt, cur;
  logic [15:0]        crc_r, crc_nxt;
  logic               out_valid_r, out_valid_nxt;
  cfb_pkg::out_item_t out_item_r, out_item_nxt;
  logic               emit;
  logic               final_byte;
  logic [7:0]         byte_val;

  // A byte is produced when an item is held and the output register is free or drains now.
  assign emit      = hold_valid && (!out_valid_r || out_ready);
  assign item_done = emit && final_byte;

  // Phase of the byte going out; a fresh item starts at the start byte or its payload.
  always_comb begin
    if (phase_r == cfb_pkg::PH_IDLE) begin
      cur = hold.first ? cfb_pkg::PH_START : cfb_pkg::PH_PAY;
    end else begin
      cur = phase_r;
    end
  end

  // Byte selection, CRC update and the successor phase.
  always_comb begin
    byte_val   = 8'h00;
    final_byte = 1'b0;
    crc_nxt    = crc_r;
    phase_nxt  = phase_r;
    unique case (cur)
      cfb_pkg::PH_START: begin
        byte_val  = cfb_pkg::START_BYTE;
        phase_nxt = cfb_pkg::PH_CMD;
      end
      cfb_pkg::PH_CMD: begin
        byte_val  = hold.command_code;
        crc_nxt   = cfb_pkg::crc_byte(crc_r, hold.command_code);
        phase_nxt = cfb_pkg::PH_HI;
      end
      cfb_pkg::PH_HI: begin
        byte_val  = hold.highest_index;
        crc_nxt   = cfb_pkg::crc_byte(crc_r, hold.highest_index);
        phase_nxt = cfb_pkg::PH_PAY;
      end
      cfb_pkg::PH_PAY: begin
        byte_val   = hold.payload_byte;
        crc_nxt    = cfb_pkg::crc_byte(crc_r, hold.payload_byte);
        final_byte = !hold.last;
        phase_nxt  = hold.last ? cfb_pkg::PH_CRCL : cfb_pkg::PH_IDLE;
      end
      cfb_pkg::PH_CRCL: begin
        byte_val  = crc_r[7:0];
        phase_nxt = cfb_pkg::PH_CRCH;
      end
      cfb_pkg::PH_CRCH: begin
        byte_val  = crc_r[15:8];
        phase_nxt = cfb_pkg::PH_END;
      end
      cfb_pkg::PH_END: begin
        byte_val   = cfb_pkg::END_BYTE;
        final_byte = 1'b1;
        crc_nxt    = cfb_pkg::CRC_INIT;
        phase_nxt  = cfb_pkg::PH_IDLE;
      end
      default: begin
        byte_val  = 8'h00;
        phase_nxt = cfb_pkg::PH_IDLE;
      end
    endcase
  end

  // Output register loads on a produced byte and empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.frame_byte = byte_val;
      out_item_nxt.run_last   = final_byte;
      out_item_nxt.frame_end  = (cur == cfb_pkg::PH_END);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State register: phase and CRC advance only on a produced byte; output valid is updated on every clock.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cfb_pkg::PH_IDLE;
      crc_r       <= cfb_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        phase_r <= phase_nxt;
        crc_r   <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/command_frame_builder_crc16_core.sv =====
// Top level of the command frame builder with CRC-16.
`timescale 1ns / 1ps

// Each payload item yields frame bytes at one byte per cycle, while the output is not
// stalled, through a single output register: a middle payload item yields 1 byte, so such
// items stream back to back; the first item of a message yields 4 bytes (start, command,
// highest index, payload), the last yields 4 (payload, CRC low, CRC high, end byte 0xAA)
// and a one-byte message yields 7. The CRC-16 (reflected 0xA001, seed 0xFFFF) is updated
// one byte per cycle, while the output is not stalled, as the command, highest index and
// payload bytes leave, and is sent low byte first. run_last marks the final byte of each
// item and frame_end the end byte. After reset the block is ready at once.
module command_frame_builder_crc16_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cfb_pkg::out_item_t out_item
);

  logic           hold_valid;
  cfb_pkg::hold_t hold;
  logic           item_done;

  cfb_intake u_intake (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_done  (item_done),
    .hold_valid (hold_valid),
    .hold       (hold)
  );

  cfb_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold       (hold),
    .item_done  (item_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ===== hdl/cfb_checker.sv =====
// Port-level checker for the frame builder, bound to the top level.
`timescale 1ns / 1ps

module cfb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input cfb_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input cfb_pkg::out_item_t out_item
);

  logic expect_start_r;

  // Tracks whether the next result item must open a new frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_start_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      expect_start_r <= out_item.frame_end;
    end
  end

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // The end byte is always the last result of its item.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_end |->
      out_item.run_last && out_item.frame_byte == cfb_pkg::END_BYTE)
    else $error("end byte not marked as last of its item");

  // Every frame opens with the start byte, which never closes an item.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && expect_start_r |->
      out_item.frame_byte == cfb_pkg::START_BYTE && !out_item.run_last)
    else $error("frame does not open with the start byte");

  // Right after reset the block is empty and takes an item.
  a_reset_ready: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_ready && !out_valid)
    else $error("block not empty and ready after reset");

endmodule

bind command_frame_builder_crc16_core cfb_checker u_cfb_checker (.*);
